// File: hw/rtl/mfu_pkg.sv
package mfu_pkg;

   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   localparam int PAGE_FIELD_BITS  = 16;
   localparam int SLOT_FIELD_BITS  = 4;
   localparam int TOTAL_FIELD_BITS = 32;
   localparam int FRAMES_CSR_BITS  = 5;

   localparam logic [FRAMES_CSR_BITS-1:0] FRAMES_RESET = 5'd4;

   typedef struct packed {
      logic [PAGE_FIELD_BITS-1:0] page_number;
      logic                       last_reference;
   } req_type;

   typedef struct packed {
      logic                        was_fault;
      logic [SLOT_FIELD_BITS-1:0]  frame_slot;
      logic                        evicted_valid;
      logic [PAGE_FIELD_BITS-1:0]  evicted_page;
      logic [TOTAL_FIELD_BITS-1:0] fault_total;
      logic                        string_done;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SCAN,
      S_VICTIM,
      S_WRITE
   } state_type;

   typedef enum logic {
      CMP_MATCH,
      CMP_MAX
   } cmp_op_type;

   typedef struct packed {
      cmp_op_type op;
      logic       first;
      logic       step;
   } cmp_ctrl_type;

endpackage

// File: hw/rtl/mfu_frame_store.sv
module mfu_frame_store
   import mfu_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   localparam int SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [SLOT_BITS-1:0]  wr_slot,
   input  logic [PAGE_BITS-1:0]  wr_page,
   input  logic [COUNT_BITS-1:0] wr_count,
   input  logic [SLOT_BITS-1:0]  rd_slot,
   output logic [PAGE_BITS-1:0]  rd_page,
   output logic [COUNT_BITS-1:0] rd_count
);

   logic [PAGE_BITS-1:0]  page_mem  [MAX_FRAMES];
   logic [COUNT_BITS-1:0] count_mem [MAX_FRAMES];
   logic [PAGE_BITS-1:0]  rd_page_ff;
   logic [COUNT_BITS-1:0] rd_count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_slot]  <= wr_page;
         count_mem[wr_slot] <= wr_count;
      end
      rd_page_ff  <= page_mem[rd_slot];
      rd_count_ff <= count_mem[rd_slot];
   end

   assign rd_page  = rd_page_ff;
   assign rd_count = rd_count_ff;

endmodule

// File: hw/rtl/mfu_cmp_unit.sv
module mfu_cmp_unit
   import mfu_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   localparam int SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
   input  logic                  clock,
   input  cmp_ctrl_type          ctrl,
   input  logic [PAGE_BITS-1:0]  key_page,
   input  logic [PAGE_BITS-1:0]  rd_page,
   input  logic [COUNT_BITS-1:0] rd_count,
   input  logic                  rd_valid,
   input  logic [SLOT_BITS-1:0]  rd_slot,
   output logic                  match,
   output logic [SLOT_BITS-1:0]  best_slot
);

   logic [COUNT_BITS-1:0] best_count_ff;
   logic [SLOT_BITS-1:0]  best_slot_ff;
   logic [COUNT_BITS-1:0] cand;
   logic                  take;

   // a slot that holds no page counts as zero
   assign cand  = rd_valid ? rd_count : '0;
   assign match = (ctrl.op == CMP_MATCH) && rd_valid && (rd_page == key_page);
   // strictly greater keeps the first of equal maxima
   assign take  = (ctrl.op == CMP_MAX) && (ctrl.first || (cand > best_count_ff));
   assign best_slot = take ? rd_slot : best_slot_ff;

   always_ff @(posedge clock) begin
      if (ctrl.step && take) begin
         best_count_ff <= cand;
         best_slot_ff  <= rd_slot;
      end
   end

endmodule

// File: hw/rtl/mfu_page_replacement.sv
// Most-frequently-used page replacement unit.
// req channel: one beat per page reference (page number, last-reference flag).
// rsp channel: one beat per reference: fault flag, slot used, evicted page,
// running fault total and an echo of the last-reference flag.
// csr port: csr_wr_en / csr_wr_data write the frame count (0 acts as 1,
// values above MAX_FRAMES act as MAX_FRAMES); write it only while idle.
// Flow, with n active frames: the table is walked one slot per cycle
// through the single read port of the frame store. A hit ends the match
// walk at its slot and goes to the write step, a miss while the table
// fills walks all n slots before the write, and a miss on a full table
// runs match walk, max-count scan, victim read and write. One item is
// in work at a time; a new request can be taken the cycle after the write.
// The result sits in an output register: a stalled rsp side does not stop
// the next request from being taken, only the write step of that next item
// waits until the previous beat has left.
// Reset (synchronous, active high) clears all slots, the pointer, the fault
// total and sets the frame count to 4. A last-reference beat clears the same
// state after its result is formed; the frame count is kept.
module mfu_page_replacement
   import mfu_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_wr_en,
   input  logic [FRAMES_CSR_BITS-1:0] csr_wr_data
);

   localparam int SLOT_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int N_BITS    = $clog2(MAX_FRAMES + 1);

   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;
   logic [MAX_FRAMES-1:0]       valid_ff, valid_in;
   logic [SLOT_BITS-1:0]        next_slot_ff, next_slot_in;
   logic                        table_full_ff, table_full_in;
   logic [TOTAL_FIELD_BITS-1:0] fault_cnt_ff, fault_cnt_in;
   logic [FRAMES_CSR_BITS-1:0]  frames_ff, frames_in;
   logic [PAGE_BITS-1:0]        key_ff, key_in;
   logic                        last_ff, last_in;
   logic [N_BITS-1:0]           n_ff, n_in;
   logic [SLOT_BITS-1:0]        rd_slot_ff, rd_slot_in;
   logic [SLOT_BITS-1:0]        step_ff, step_in;
   logic [SLOT_BITS-1:0]        slot_ff, slot_in;
   logic                        fault_ff, fault_in;
   logic [COUNT_BITS-1:0]       wcount_ff, wcount_in;
   logic                        ev_valid_ff, ev_valid_in;
   logic [PAGE_BITS-1:0]        ev_page_ff, ev_page_in;

   logic                        req_accept;
   logic                        rsp_free;
   logic [N_BITS-1:0]           active_n;
   logic [SLOT_BITS-1:0]        last_slot;
   logic                        full_eff;
   logic [TOTAL_FIELD_BITS-1:0] fault_sat;
   logic                        wr_en;
   cmp_ctrl_type                cmp_ctrl;
   logic [PAGE_BITS-1:0]        rd_page;
   logic [COUNT_BITS-1:0]       rd_count;
   logic                        match;
   logic [SLOT_BITS-1:0]        best_slot;

   function automatic logic [SLOT_BITS-1:0] wrap_next(input logic [SLOT_BITS-1:0] s,
                                                      input logic [N_BITS-1:0] n);
      logic [N_BITS-1:0] inc;
      inc = N_BITS'(s) + N_BITS'(1);
      return (inc < n) ? SLOT_BITS'(inc) : '0;
   endfunction

   mfu_frame_store #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_slot  (slot_ff),
      .wr_page  (key_ff),
      .wr_count (wcount_ff),
      .rd_slot  (rd_slot_in),
      .rd_page  (rd_page),
      .rd_count (rd_count)
   );

   mfu_cmp_unit #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_cmp (
      .clock     (clock),
      .ctrl      (cmp_ctrl),
      .key_page  (key_ff),
      .rd_page   (rd_page),
      .rd_count  (rd_count),
      .rd_valid  (valid_ff[rd_slot_ff]),
      .rd_slot   (rd_slot_ff),
      .match     (match),
      .best_slot (best_slot)
   );

   always_comb begin
      if (frames_ff == '0) begin
         active_n = N_BITS'(1);
      end else if (32'(frames_ff) > MAX_FRAMES) begin
         active_n = N_BITS'(MAX_FRAMES);
      end else begin
         active_n = N_BITS'(frames_ff);
      end
   end

   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign last_slot  = SLOT_BITS'(n_ff - N_BITS'(1));
   assign full_eff   = table_full_ff || !(N_BITS'(next_slot_ff) < n_ff);
   assign fault_sat  = (fault_cnt_ff == '1) ? fault_cnt_ff : fault_cnt_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (match) begin
               state_in = S_WRITE;
            end else if (rd_slot_ff == last_slot) begin
               state_in = full_eff ? S_SCAN : S_WRITE;
            end
         end
         S_SCAN: begin
            if (step_ff == last_slot) state_in = S_VICTIM;
         end
         S_VICTIM: state_in = S_WRITE;
         S_WRITE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      wr_en          = (state_ff == S_WRITE) && rsp_free;
      cmp_ctrl.op    = (state_ff == S_SCAN) ? CMP_MAX : CMP_MATCH;
      cmp_ctrl.first = (step_ff == '0);
      cmp_ctrl.step  = (state_ff == S_SCAN);
   end

   // datapath; the store read address is rd_slot_in, so its data matches rd_slot_ff
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      valid_in      = valid_ff;
      next_slot_in  = next_slot_ff;
      table_full_in = table_full_ff;
      fault_cnt_in  = fault_cnt_ff;
      frames_in     = csr_wr_en ? csr_wr_data : frames_ff;
      key_in        = key_ff;
      last_in       = last_ff;
      n_in          = n_ff;
      rd_slot_in    = rd_slot_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      fault_in      = fault_ff;
      wcount_in     = wcount_ff;
      ev_valid_in   = ev_valid_ff;
      ev_page_in    = ev_page_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in     = PAGE_BITS'(req_data.page_number);
               last_in    = req_data.last_reference;
               n_in       = active_n;
               rd_slot_in = '0;
            end
         end
         S_SEARCH: begin
            if (match) begin
               slot_in     = rd_slot_ff;
               fault_in    = 1'b0;
               wcount_in   = (rd_count == '1) ? rd_count : rd_count + 1'b1;
               ev_valid_in = 1'b0;
               ev_page_in  = '0;
            end else if (rd_slot_ff == last_slot) begin
               fault_in    = 1'b1;
               wcount_in   = COUNT_BITS'(1);
               ev_valid_in = 1'b0;
               ev_page_in  = '0;
               if (!full_eff) begin
                  slot_in       = next_slot_ff;
                  next_slot_in  = wrap_next(next_slot_ff, n_ff);
                  table_full_in = (wrap_next(next_slot_ff, n_ff) == '0);
               end else begin
                  // a stale pointer past the frame count starts the scan at slot 0
                  table_full_in = 1'b1;
                  rd_slot_in    = (N_BITS'(next_slot_ff) < n_ff) ? next_slot_ff : '0;
                  step_in       = '0;
               end
            end else begin
               rd_slot_in = rd_slot_ff + 1'b1;
            end
         end
         S_SCAN: begin
            step_in    = step_ff + 1'b1;
            rd_slot_in = wrap_next(rd_slot_ff, n_ff);
            if (step_ff == last_slot) begin
               slot_in    = best_slot;
               rd_slot_in = best_slot;
            end
         end
         S_VICTIM: begin
            ev_valid_in  = valid_ff[slot_ff];
            ev_page_in   = valid_ff[slot_ff] ? rd_page : '0;
            next_slot_in = wrap_next(slot_ff, n_ff);
         end
         S_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.was_fault       = fault_ff;
               rsp_in.frame_slot      = SLOT_FIELD_BITS'(slot_ff);
               rsp_in.evicted_valid   = ev_valid_ff;
               rsp_in.evicted_page    = PAGE_FIELD_BITS'(ev_page_ff);
               rsp_in.fault_total     = fault_ff ? fault_sat : fault_cnt_ff;
               rsp_in.string_done     = last_ff;
               valid_in[slot_ff]      = 1'b1;
               if (fault_ff) fault_cnt_in = fault_sat;
               if (last_ff) begin
                  valid_in      = '0;
                  next_slot_in  = '0;
                  table_full_in = 1'b0;
                  fault_cnt_in  = '0;
               end
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         next_slot_ff  <= '0;
         table_full_ff <= 1'b0;
         fault_cnt_ff  <= '0;
         frames_ff     <= FRAMES_RESET;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
         next_slot_ff  <= next_slot_in;
         table_full_ff <= table_full_in;
         fault_cnt_ff  <= fault_cnt_in;
         frames_ff     <= frames_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      key_ff      <= key_in;
      last_ff     <= last_in;
      n_ff        <= n_in;
      rd_slot_ff  <= rd_slot_in;
      slot_ff     <= slot_in;
      fault_ff    <= fault_in;
      wcount_ff   <= wcount_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_SEARCH && rd_slot_ff == '0)
      else $error("request beat did not start the walk at slot 0");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> 32'(slot_ff) < 32'(n_ff))
      else $error("chosen slot outside the active frames");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_fault |-> !rsp_data.evicted_valid)
      else $error("hit beat reports an eviction");

   a_full_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> table_full_ff)
      else $error("replacement scan on a table not marked full");

endmodule
